FILE: rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every edge outside reset.
`define CHK_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("check failed: property does not hold");

// Expression must never be true outside reset.
`define CHK_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("check failed: forbidden condition seen");

`endif

FILE: rtl/aepr_pkg.sv
package aepr_pkg;

  // Fixed field widths
  localparam int IdW   = 8;
  localparam int PrioW = 5;
  localparam int CmdW  = 2;
  localparam int StatW = 2;
  localparam int NewpW = 4;
  localparam int InDataW  = 24;
  localparam int OutDataW = 16;

  // Commands
  localparam logic [CmdW-1:0] CMD_ADD    = 2'd0;
  localparam logic [CmdW-1:0] CMD_PICK   = 2'd1;
  localparam logic [CmdW-1:0] CMD_REMOVE = 2'd2;

  // Result status codes
  localparam logic [StatW-1:0] STAT_OK       = 2'd0;
  localparam logic [StatW-1:0] STAT_EMPTY    = 2'd1;
  localparam logic [StatW-1:0] STAT_NOTFOUND = 2'd2;

  localparam logic [4:0] LEVELS_RESET = 5'd4;

endpackage

FILE: rtl/aepr_ram.sv
module aepr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                          clk_i,
  input  logic                                          we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  waddr_i,
  input  logic [Width-1:0]                              wdata_i,
  input  logic                                          re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0]  raddr_i,
  output logic [Width-1:0]                              rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // One write port, one registered read port (read holds when not enabled)
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule

FILE: rtl/active_expired_priority_runqueue.sv
// Channel   | Direction | tdata fields (low bit up)
// ----------+-----------+--------------------------------------------------------
// s_axis    | in        | command[1:0] process_id[9:2] dyn_prio[14:10]
//           |           | stat_prio[19:15], zero fill to 24
// m_axis    | out       | status[1:0] chosen_id[9:2] new_priority[13:10]
//           |           | queues_swapped[14], zero fill to 16
// cfg       | in        | levels_in_use[4:0], written when cfg_we_i is high
//
// Each item runs from idle through an execute state, plus a finish state on
// the registered read of the link/head/tail/slot memories for add to a
// nonempty level, remove of a queued id, and pick that finds an id. A new
// item is accepted only in idle.
// Reset clears the level flags, queued flags, bank select and output valid;
// the memories need no clearing. A full output register holds the item in
// its execute or finish cycle until the result is taken.
module active_expired_priority_runqueue #(
  parameter int LEVELS    = 16,
  parameter int MAX_PROCS = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [4:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [aepr_pkg::InDataW-1:0]  s_axis_tdata,  // command, process_id, dyn prio, stat prio
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [aepr_pkg::OutDataW-1:0] m_axis_tdata   // status, chosen_id, new_priority, swapped
);
  localparam int IW    = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int PW    = $clog2(MAX_PROCS + 1);
  localparam int Slots = 2 * LEVELS;
  localparam int SW    = (Slots > 1) ? $clog2(Slots) : 1;
  localparam logic [PW-1:0] NilPtr = PW'(MAX_PROCS);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIN  = 2'd2;

  // Control state
  logic [1:0]       state_q, state_d;
  logic             bank_q, bank_d;
  logic [4:0]       levels_q;
  logic [Slots-1:0] nonempty_q, nonempty_d;
  logic [MAX_PROCS-1:0] queued_q, queued_d;

  // Captured item and pending data
  logic [aepr_pkg::CmdW-1:0]  cmd_q;
  logic [aepr_pkg::IdW-1:0]   pid_q;
  logic [aepr_pkg::PrioW-1:0] dp_q, sp_q;
  logic [SW-1:0]              slot_q, slot_d;
  logic                       swap_q, swap_d;
  logic [aepr_pkg::NewpW-1:0] newp_q, newp_d;

  // Output register
  logic                         ovalid_q, ovalid_d;
  logic [aepr_pkg::StatW-1:0]   ostat_q, ostat_d;
  logic [aepr_pkg::IdW-1:0]     oid_q, oid_d;
  logic [aepr_pkg::NewpW-1:0]   onewp_q, onewp_d;
  logic                         oswap_q, oswap_d;

  // Memory ports
  logic          nx_we, nx_re, pv_we, pv_re, hd_we, hd_re, tl_we, tl_re, sl_we, sl_re;
  logic [IW-1:0] nx_wa, nx_ra, pv_wa, pv_ra, sl_wa, sl_ra;
  logic [SW-1:0] hd_wa, hd_ra, tl_wa, tl_ra;
  logic [PW-1:0] nx_wd, nx_rd, pv_wd, pv_rd, hd_wd, hd_rd, tl_wd, tl_rd;
  logic [SW-1:0] sl_wd, sl_rd;

  // Derived item values
  logic [IW+aepr_pkg::IdW-1:0] id_wide;
  logic [PW+aepr_pkg::IdW-1:0] ptr_wide;
  logic [IW-1:0]  id_idx;
  logic [PW-1:0]  id_ptr;
  logic           id_ok, is_queued;
  logic [7:0]     eff;
  logic signed [7:0] lvl_raw, add_lvl;
  logic           add_bank;
  logic [SW-1:0]  add_slot, rm_slot;
  logic           rm_pre;
  logic           out_free, accept;
  logic           fnd_a, fnd_b;
  logic [SW-1:0]  slot_a, slot_b;
  logic [aepr_pkg::IdW+PW-1:0] head_wide;

  assign accept        = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign out_free      = !ovalid_q || m_axis_tready;

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = {1'b0, oswap_q, onewp_q, oid_q, ostat_q};

  // Id as memory index and as link pointer
  assign id_wide   = {{IW{1'b0}}, pid_q};
  assign ptr_wide  = {{PW{1'b0}}, pid_q};
  assign id_idx    = id_wide[IW-1:0];
  assign id_ptr    = ptr_wide[PW-1:0];
  assign id_ok     = 32'(pid_q) < 32'(MAX_PROCS);
  assign is_queued = id_ok && queued_q[id_idx];
  assign head_wide = {{aepr_pkg::IdW{1'b0}}, hd_rd};

  // Effective level count, 1..LEVELS
  always_comb begin
    if (levels_q == 5'd0) begin
      eff = 8'd1;
    end else if ({3'b000, levels_q} > 8'(LEVELS)) begin
      eff = 8'(LEVELS);
    end else begin
      eff = {3'b000, levels_q};
    end
  end

  // Add: level and bank, saturated into range
  always_comb begin
    if (dp_q[4]) begin
      lvl_raw = $signed({3'b000, sp_q}) - 8'sd1;
    end else begin
      lvl_raw = $signed({3'b000, dp_q});
    end
    if (lvl_raw < 8'sd0) begin
      add_lvl = 8'sd0;
    end else if (lvl_raw > $signed(eff - 8'd1)) begin
      add_lvl = $signed(eff - 8'd1);
    end else begin
      add_lvl = lvl_raw;
    end
    add_bank = bank_q ^ dp_q[4];
    add_slot = (add_bank ? SW'(LEVELS) : SW'(0)) + SW'(add_lvl);
    rm_slot  = (bank_q ? SW'(LEVELS) : SW'(0)) + SW'(dp_q);
    rm_pre   = !dp_q[4] && ({3'b000, dp_q} < 8'(LEVELS)) && is_queued;
  end

  // Pick: highest nonempty level in each bank, below the effective count
  always_comb begin
    fnd_a  = 1'b0;
    fnd_b  = 1'b0;
    slot_a = '0;
    slot_b = '0;
    for (int i = 0; i < LEVELS; i++) begin
      if (8'(i) < eff) begin
        if (nonempty_q[(bank_q ? LEVELS : 0) + i]) begin
          fnd_a  = 1'b1;
          slot_a = SW'((bank_q ? LEVELS : 0) + i);
        end
        if (nonempty_q[(bank_q ? 0 : LEVELS) + i]) begin
          fnd_b  = 1'b1;
          slot_b = SW'((bank_q ? 0 : LEVELS) + i);
        end
      end
    end
  end

  // Sequencer
  always_comb begin
    state_d    = state_q;
    bank_d     = bank_q;
    nonempty_d = nonempty_q;
    queued_d   = queued_q;
    slot_d     = slot_q;
    swap_d     = swap_q;
    newp_d     = newp_q;
    ovalid_d   = ovalid_q && !m_axis_tready;
    ostat_d    = ostat_q;
    oid_d      = oid_q;
    onewp_d    = onewp_q;
    oswap_d    = oswap_q;
    nx_we = 1'b0; nx_wa = '0; nx_wd = '0; nx_re = 1'b0; nx_ra = id_idx;
    pv_we = 1'b0; pv_wa = '0; pv_wd = '0; pv_re = 1'b0; pv_ra = id_idx;
    hd_we = 1'b0; hd_wa = '0; hd_wd = '0; hd_re = 1'b0; hd_ra = '0;
    tl_we = 1'b0; tl_wa = '0; tl_wd = '0; tl_re = 1'b0; tl_ra = add_slot;
    sl_we = 1'b0; sl_wa = id_idx; sl_wd = add_slot; sl_re = 1'b0; sl_ra = id_idx;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_EXEC;
        end
      end

      S_EXEC: begin
        if (out_free) begin
          // default result: finish now with all-zero fields
          state_d  = S_IDLE;
          ovalid_d = 1'b1;
          ostat_d  = aepr_pkg::STAT_OK;
          oid_d    = '0;
          onewp_d  = '0;
          oswap_d  = 1'b0;
          case (cmd_q)
            aepr_pkg::CMD_ADD: begin
              onewp_d = aepr_pkg::NewpW'(add_lvl);
              newp_d  = aepr_pkg::NewpW'(add_lvl);
              if (id_ok && !is_queued) begin
                queued_d[id_idx] = 1'b1;
                nx_we = 1'b1; nx_wa = id_idx; nx_wd = NilPtr;
                sl_we = 1'b1;
                slot_d = add_slot;
                if (nonempty_q[add_slot]) begin
                  // need current tail before linking
                  tl_re    = 1'b1;
                  state_d  = S_FIN;
                  ovalid_d = ovalid_q && !m_axis_tready;
                end else begin
                  pv_we = 1'b1; pv_wa = id_idx; pv_wd = NilPtr;
                  hd_we = 1'b1; hd_wa = add_slot; hd_wd = id_ptr;
                  tl_we = 1'b1; tl_wa = add_slot; tl_wd = id_ptr;
                  nonempty_d[add_slot] = 1'b1;
                end
              end
            end
            aepr_pkg::CMD_PICK: begin
              if (fnd_a || fnd_b) begin
                hd_re    = 1'b1;
                hd_ra    = fnd_a ? slot_a : slot_b;
                swap_d   = !fnd_a;
                bank_d   = bank_q ^ !fnd_a;
                state_d  = S_FIN;
                ovalid_d = ovalid_q && !m_axis_tready;
              end else begin
                bank_d  = !bank_q;
                ostat_d = aepr_pkg::STAT_EMPTY;
                oswap_d = 1'b1;
              end
            end
            aepr_pkg::CMD_REMOVE: begin
              if (rm_pre) begin
                nx_re    = 1'b1;
                pv_re    = 1'b1;
                sl_re    = 1'b1;
                slot_d   = rm_slot;
                state_d  = S_FIN;
                ovalid_d = ovalid_q && !m_axis_tready;
              end else begin
                ostat_d = aepr_pkg::STAT_NOTFOUND;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_FIN: begin
        if (out_free) begin
          state_d  = S_IDLE;
          ovalid_d = 1'b1;
          ostat_d  = aepr_pkg::STAT_OK;
          oid_d    = '0;
          onewp_d  = '0;
          oswap_d  = 1'b0;
          case (cmd_q)
            aepr_pkg::CMD_ADD: begin
              // append behind old tail
              onewp_d = newp_q;
              pv_we = 1'b1; pv_wa = id_idx; pv_wd = tl_rd;
              nx_we = 1'b1; nx_wa = tl_rd[IW-1:0]; nx_wd = id_ptr;
              tl_we = 1'b1; tl_wa = slot_q; tl_wd = id_ptr;
            end
            aepr_pkg::CMD_PICK: begin
              oid_d   = head_wide[aepr_pkg::IdW-1:0];
              oswap_d = swap_q;
            end
            default: begin
              // remove: unlink when the id sits in the addressed level
              if (sl_rd == slot_q) begin
                queued_d[id_idx] = 1'b0;
                if (pv_rd != NilPtr) begin
                  nx_we = 1'b1; nx_wa = pv_rd[IW-1:0]; nx_wd = nx_rd;
                end else begin
                  hd_we = 1'b1; hd_wa = slot_q; hd_wd = nx_rd;
                end
                if (nx_rd != NilPtr) begin
                  pv_we = 1'b1; pv_wa = nx_rd[IW-1:0]; pv_wd = pv_rd;
                end else begin
                  tl_we = 1'b1; tl_wa = slot_q; tl_wd = pv_rd;
                end
                if (pv_rd == NilPtr && nx_rd == NilPtr) begin
                  nonempty_d[slot_q] = 1'b0;
                end
              end else begin
                ostat_d = aepr_pkg::STAT_NOTFOUND;
              end
            end
          endcase
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      bank_q     <= 1'b0;
      levels_q   <= aepr_pkg::LEVELS_RESET;
      nonempty_q <= '0;
      queued_q   <= '0;
      ovalid_q   <= 1'b0;
    end else begin
      state_q    <= state_d;
      bank_q     <= bank_d;
      nonempty_q <= nonempty_d;
      queued_q   <= queued_d;
      ovalid_q   <= ovalid_d;
      if (cfg_we_i) begin
        levels_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q <= s_axis_tdata[1:0];
      pid_q <= s_axis_tdata[9:2];
      dp_q  <= s_axis_tdata[14:10];
      sp_q  <= s_axis_tdata[19:15];
    end
    slot_q  <= slot_d;
    swap_q  <= swap_d;
    newp_q  <= newp_d;
    ostat_q <= ostat_d;
    oid_q   <= oid_d;
    onewp_q <= onewp_d;
    oswap_q <= oswap_d;
  end

  // Link, head, tail and slot memories
  aepr_ram #(.Width(PW), .Depth(MAX_PROCS)) u_next (
    .clk_i, .we_i(nx_we), .waddr_i(nx_wa), .wdata_i(nx_wd),
    .re_i(nx_re), .raddr_i(nx_ra), .rdata_o(nx_rd)
  );
  aepr_ram #(.Width(PW), .Depth(MAX_PROCS)) u_prev (
    .clk_i, .we_i(pv_we), .waddr_i(pv_wa), .wdata_i(pv_wd),
    .re_i(pv_re), .raddr_i(pv_ra), .rdata_o(pv_rd)
  );
  aepr_ram #(.Width(PW), .Depth(Slots)) u_head (
    .clk_i, .we_i(hd_we), .waddr_i(hd_wa), .wdata_i(hd_wd),
    .re_i(hd_re), .raddr_i(hd_ra), .rdata_o(hd_rd)
  );
  aepr_ram #(.Width(PW), .Depth(Slots)) u_tail (
    .clk_i, .we_i(tl_we), .waddr_i(tl_wa), .wdata_i(tl_wd),
    .re_i(tl_re), .raddr_i(tl_ra), .rdata_o(tl_rd)
  );
  aepr_ram #(.Width(SW), .Depth(MAX_PROCS)) u_slot (
    .clk_i, .we_i(sl_we), .waddr_i(sl_wa), .wdata_i(sl_wd),
    .re_i(sl_re), .raddr_i(sl_ra), .rdata_o(sl_rd)
  );
endmodule

FILE: rtl/aepr_checker.sv
`include "assert_macros.svh"

module aepr_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata
);
  // Stalled result holds
  `CHK_HOLDS(a_out_hold, clk_i, rst_ni, m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
  // One item in flight: no accept right after an accept
  `CHK_HOLDS(a_one_item, clk_i, rst_ni, s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
  // A new result only arrives while an item is in work
  `CHK_HOLDS(a_res_busy, clk_i, rst_ni, $rose(m_axis_tvalid) |-> !$past(s_axis_tready))
  // Not-found results carry no id and no swap
  `CHK_NEVER(a_nf_clean, clk_i, rst_ni,
    m_axis_tvalid && m_axis_tdata[1:0] == aepr_pkg::STAT_NOTFOUND &&
    (m_axis_tdata[9:2] != 8'd0 || m_axis_tdata[14]))
endmodule

bind active_expired_priority_runqueue aepr_checker u_aepr_checker (
  .clk_i(clk_i),
  .rst_ni(rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata(m_axis_tdata)
);
